[hdl/fir_filter_direct_form_assert.svh]
// assertion macros for the fir filter checker
// no dependencies; included by the checker file only
`ifndef FIR_FILTER_DIRECT_FORM_ASSERT_SVH
`define FIR_FILTER_DIRECT_FORM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fir filter check failed");

// next-cycle implication, disabled during reset
`define FIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fir filter check failed");

`endif

[hdl/fir_pkg.sv]
// shared types and constants for the direct-form fir filter
// no dependencies; used by every module of the block
package fir_pkg;

    // default parameter values
    localparam int DEF_MAX_TAPS     = 16;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // fixed field widths
    localparam int TAP_WIDTH       = 16;
    localparam int TAP_FRAC        = 15;
    localparam int TAP_INDEX_WIDTH = 4;
    localparam int TAP_COUNT_WIDTH = 5;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH  = 5;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TAP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COMPLEX_INPUT = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_KEEP_IMAG     = 2'd2;

    // item kinds carried in tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TAP    = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic load_sample;
        logic load_tap;
        logic rotate;
        logic mac_en;
        logic acc_clr;
        logic acc_add;
        logic out_load;
    } t_ctrl;

endpackage

[hdl/fir_tap_store.sv]
// sample window and tap table as rotating shift registers
// depends on fir_pkg
module fir_tap_store #(
    parameter int MAX_TAPS     = fir_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = fir_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fir_pkg::t_ctrl                         i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_sample_im,
    input  logic [fir_pkg::TAP_INDEX_WIDTH-1:0]    i_tap_index,
    input  logic signed [fir_pkg::TAP_WIDTH-1:0]   i_tap_value,
    output logic signed [SAMPLE_WIDTH-1:0]         o_head_re,
    output logic signed [SAMPLE_WIDTH-1:0]         o_head_im,
    output logic signed [fir_pkg::TAP_WIDTH-1:0]   o_head_coef
);

    // entry 0 is the newest sample, the rest is the delay line
    logic signed [SAMPLE_WIDTH-1:0]       r_win_re [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0]       r_win_im [MAX_TAPS];
    logic signed [fir_pkg::TAP_WIDTH-1:0] r_coef   [MAX_TAPS];

    // window: shift in on a sample, rotate one place per mac step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_win_re[i] <= '0;
                r_win_im[i] <= '0;
            end
        end else if (i_ctrl.load_sample) begin
            r_win_re[0] <= i_sample_re;
            r_win_im[0] <= i_sample_im;
            for (int i = 1; i < MAX_TAPS; i++) begin
                r_win_re[i] <= r_win_re[i-1];
                r_win_im[i] <= r_win_im[i-1];
            end
        end else if (i_ctrl.rotate) begin
            for (int i = 0; i < MAX_TAPS - 1; i++) begin
                r_win_re[i] <= r_win_re[i+1];
                r_win_im[i] <= r_win_im[i+1];
            end
            r_win_re[MAX_TAPS-1] <= r_win_re[0];
            r_win_im[MAX_TAPS-1] <= r_win_im[0];
        end
    end

    // tap table: indexed write when idle, rotates with the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_ctrl.load_tap) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                if (int'(i_tap_index) == i) begin
                    r_coef[i] <= i_tap_value;
                end
            end
        end else if (i_ctrl.rotate) begin
            for (int i = 0; i < MAX_TAPS - 1; i++) begin
                r_coef[i] <= r_coef[i+1];
            end
            r_coef[MAX_TAPS-1] <= r_coef[0];
        end
    end

    assign o_head_re   = r_win_re[0];
    assign o_head_im   = r_win_im[0];
    assign o_head_coef = r_coef[0];

endmodule

[hdl/fir_mac.sv]
// shared multiply-accumulate unit with rounding, saturation and result register
// depends on fir_pkg
module fir_mac #(
    parameter int MAX_TAPS     = fir_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = fir_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 i_clk,
    input  fir_pkg::t_ctrl                       i_ctrl,
    input  logic                                 i_keep_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_head_re,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_head_im,
    input  logic signed [fir_pkg::TAP_WIDTH-1:0] i_head_coef,
    output logic signed [SAMPLE_WIDTH-1:0]       o_out_re,
    output logic signed [SAMPLE_WIDTH-1:0]       o_out_im,
    output logic                                 o_sat
);

    localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PW    = SAMPLE_WIDTH + fir_pkg::TAP_WIDTH;
    localparam int ACC_W = PW + CNT_W + 1;
    localparam int Q_W   = ACC_W - fir_pkg::TAP_FRAC;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (fir_pkg::TAP_FRAC - 1));
    localparam logic signed [Q_W-1:0]   SAT_HI   =
        Q_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0]   SAT_LO   = Q_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    logic signed [PW-1:0]    w_mul_re;
    logic signed [PW-1:0]    w_mul_im;
    logic signed [PW-1:0]    r_prod_re;
    logic signed [PW-1:0]    r_prod_im;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic [SAMPLE_WIDTH:0]   w_rs_re;
    logic [SAMPLE_WIDTH:0]   w_rs_im;
    logic signed [SAMPLE_WIDTH-1:0] r_out_re;
    logic signed [SAMPLE_WIDTH-1:0] r_out_im;
    logic                           r_sat;

    // round half up by the tap fraction, then clip; msb is the clip flag
    function automatic logic [SAMPLE_WIDTH:0] f_round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] shifted;
        logic signed [Q_W-1:0]   q;
        logic [SAMPLE_WIDTH:0]   res;
        sum     = acc + RND_HALF;
        shifted = sum >>> fir_pkg::TAP_FRAC;
        q       = $signed(shifted[Q_W-1:0]);
        if (q > SAT_HI) begin
            res = {1'b1, SAT_HI[SAMPLE_WIDTH-1:0]};
        end else if (q < SAT_LO) begin
            res = {1'b1, SAT_LO[SAMPLE_WIDTH-1:0]};
        end else begin
            res = {1'b0, q[SAMPLE_WIDTH-1:0]};
        end
        return res;
    endfunction

    assign w_mul_re = i_head_re * i_head_coef;
    assign w_mul_im = i_head_im * i_head_coef;

    // product register, zero for taps beyond the count in use
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mac_en) begin
            r_prod_re <= w_mul_re;
            r_prod_im <= w_mul_im;
        end else begin
            r_prod_re <= '0;
            r_prod_im <= '0;
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_ctrl.acc_add) begin
            r_acc_re <= r_acc_re + ACC_W'(r_prod_re);
            r_acc_im <= r_acc_im + ACC_W'(r_prod_im);
        end
    end

    assign w_rs_re = f_round_sat(r_acc_re);
    assign w_rs_im = f_round_sat(r_acc_im);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_re <= $signed(w_rs_re[SAMPLE_WIDTH-1:0]);
            r_out_im <= i_keep_imag ? $signed(w_rs_im[SAMPLE_WIDTH-1:0]) : '0;
            r_sat    <= w_rs_re[SAMPLE_WIDTH] | (i_keep_imag & w_rs_im[SAMPLE_WIDTH]);
        end
    end

    assign o_out_re = r_out_re;
    assign o_out_im = r_out_im;
    assign o_sat    = r_sat;

endmodule

[hdl/fir_ctrl.sv]
// sequencer: accepts items, steps the mac over every tap, hands over the result
// depends on fir_pkg
module fir_ctrl #(
    parameter int MAX_TAPS = fir_pkg::DEF_MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_func,
    input  logic                                i_out_ready,
    input  logic [fir_pkg::TAP_COUNT_WIDTH-1:0] i_tap_count,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    output fir_pkg::t_ctrl                      o_ctrl
);

    localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CMP_W = (CNT_W > fir_pkg::TAP_COUNT_WIDTH) ? CNT_W
                                                              : fir_pkg::TAP_COUNT_WIDTH;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);

    fir_pkg::t_state r_state;
    fir_pkg::t_state n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_active;

    // a tap position takes part while it lies below the tap count
    assign w_active = CMP_W'(r_count) < CMP_W'(i_tap_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fir_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            fir_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == fir_pkg::FUNC_TAP) begin
                        o_ctrl.load_tap = 1'b1;
                    end else begin
                        o_ctrl.load_sample = 1'b1;
                        o_ctrl.acc_clr     = 1'b1;
                        n_count            = '0;
                        n_state            = fir_pkg::ST_MAC;
                    end
                end
            end
            fir_pkg::ST_MAC: begin
                o_ctrl.rotate  = 1'b1;
                o_ctrl.mac_en  = w_active;
                o_ctrl.acc_add = (r_count != '0);
                if (r_count == CNT_LAST) begin
                    n_state = fir_pkg::ST_DRAIN;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            fir_pkg::ST_DRAIN: begin
                o_ctrl.acc_add = 1'b1;
                n_state        = fir_pkg::ST_ROUND;
            end
            fir_pkg::ST_ROUND: begin
                // wait for any earlier result to leave the output register
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.out_load = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = fir_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fir_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[hdl/fir_filter_direct_form.sv]
// Direct-form FIR filter, one shared multiply-accumulate stepping over every tap position.
// A sample starts a pass: ST_MAC, as the single mac unit walks the rotating window and
// tap table, then ST_DRAIN and ST_ROUND, which waits for an earlier result to leave.
// No new sample is taken until the pass ends. A tap write gives no result.
// Reset (i_rst_n low, synchronous) zeroes config and control regs, delay line, tap table.
module fir_filter_direct_form #(
    parameter int MAX_TAPS     = fir_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = fir_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [fir_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [fir_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: sample_re, sample_im, tap_index, tap_value, zero fill
    input  logic [((2*SAMPLE_WIDTH+20+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: func
    input  logic                                i_s_axis_tuser,
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: out_re, out_im, zero fill
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // tuser: saturated
    output logic                                o_m_axis_tuser
);

    localparam int OUT_W = ((2*SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IX_LO = 2*SAMPLE_WIDTH;
    localparam int TV_LO = IX_LO + fir_pkg::TAP_INDEX_WIDTH;

    logic [fir_pkg::TAP_COUNT_WIDTH-1:0]  r_tap_count;
    logic                                 r_complex_input;
    logic                                 r_keep_imag;
    fir_pkg::t_ctrl                       w_ctrl;
    logic signed [SAMPLE_WIDTH-1:0]       w_sample_re;
    logic signed [SAMPLE_WIDTH-1:0]       w_sample_im;
    logic signed [SAMPLE_WIDTH-1:0]       w_head_re;
    logic signed [SAMPLE_WIDTH-1:0]       w_head_im;
    logic signed [fir_pkg::TAP_WIDTH-1:0] w_head_coef;
    logic signed [SAMPLE_WIDTH-1:0]       w_out_re;
    logic signed [SAMPLE_WIDTH-1:0]       w_out_im;
    logic                                 w_sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count     <= '0;
            r_complex_input <= 1'b0;
            r_keep_imag     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fir_pkg::REG_TAP_COUNT: begin
                    r_tap_count <= i_cfg_data[fir_pkg::TAP_COUNT_WIDTH-1:0];
                end
                fir_pkg::REG_COMPLEX_INPUT: begin
                    r_complex_input <= i_cfg_data[0];
                end
                fir_pkg::REG_KEEP_IMAG: begin
                    r_keep_imag <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // unpack the input transfer; imaginary part is zero in real mode
    assign w_sample_re = $signed(i_s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign w_sample_im = r_complex_input ? $signed(i_s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])
                                         : '0;

    fir_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_func   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .i_tap_count (r_tap_count),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_ctrl      (w_ctrl)
    );

    fir_tap_store #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_sample_re (w_sample_re),
        .i_sample_im (w_sample_im),
        .i_tap_index (i_s_axis_tdata[TV_LO-1:IX_LO]),
        .i_tap_value ($signed(i_s_axis_tdata[TV_LO+fir_pkg::TAP_WIDTH-1:TV_LO])),
        .o_head_re   (w_head_re),
        .o_head_im   (w_head_im),
        .o_head_coef (w_head_coef)
    );

    fir_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_keep_imag (r_keep_imag),
        .i_head_re   (w_head_re),
        .i_head_im   (w_head_im),
        .i_head_coef (w_head_coef),
        .o_out_re    (w_out_re),
        .o_out_im    (w_out_im),
        .o_sat       (w_sat)
    );

    // pack the output transfer
    assign o_m_axis_tdata = OUT_W'({w_out_im, w_out_re});
    assign o_m_axis_tuser = w_sat;

endmodule

[hdl/fir_filter_direct_form_checker.sv]
// port-level checks on the fir filter handshakes and sequencing
// depends on fir_pkg and fir_filter_direct_form_assert.svh; bound to the top level
`include "fir_filter_direct_form_assert.svh"

module fir_filter_direct_form_checker #(
    parameter int SAMPLE_WIDTH = fir_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic                                 i_s_axis_tuser,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  o_m_axis_tdata,
    input logic                                 o_m_axis_tuser
);

    logic w_s_fire;

    assign w_s_fire = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result holds its payload
    `FIR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // a sample transfer keeps the block busy in the next cycle
    `FIR_ASSERT_NXT(a_sample_busy, i_clk, i_rst_n, w_s_fire && (i_s_axis_tuser == fir_pkg::FUNC_SAMPLE), !o_s_axis_tready)

    // a tap write leaves the block ready again and makes no result
    `FIR_ASSERT_NXT(a_tap_quick, i_clk, i_rst_n, w_s_fire && (i_s_axis_tuser == fir_pkg::FUNC_TAP), o_s_axis_tready && !$rose(o_m_axis_tvalid))

    // a new result only comes out of a busy period
    `FIR_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

endmodule

bind fir_filter_direct_form fir_filter_direct_form_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[bench/tb_fir_filter_direct_form.sv]
`timescale 1ns / 100ps
// self-checking bench for the direct-form fir filter: directed items, then random phases
// depends on fir_pkg and fir_filter_direct_form; a scoreboard class predicts every result

localparam int TB_TAPS  = fir_pkg::DEF_MAX_TAPS;
localparam int TB_SW    = fir_pkg::DEF_SAMPLE_WIDTH;
localparam int TB_IN_W  = ((2*TB_SW+20+7)/8)*8;
localparam int TB_OUT_W = ((2*TB_SW+7)/8)*8;

// one filtered sample as it should leave the block
typedef struct {
    logic [TB_SW-1:0] re;
    logic [TB_SW-1:0] im;
    logic             sat;
} t_filt_out;

// fir predictor and result checker
class fir_scoreboard;
    int unsigned tap_cnt;
    bit          cplx_in;
    bit          keep_im;
    longint      line_re[TB_TAPS-1];
    longint      line_im[TB_TAPS-1];
    longint      coef[TB_TAPS];
    t_filt_out   filtered_q[$];
    int          errors;

    function new();
        tap_cnt = 0;
        cplx_in = 0;
        keep_im = 0;
        errors  = 0;
        foreach (line_re[i]) begin
            line_re[i] = 0;
            line_im[i] = 0;
        end
        foreach (coef[i]) coef[i] = 0;
    endfunction

    function int pending();
        return filtered_q.size();
    endfunction

    // register write; unmapped indexes are dropped
    function void write_reg(logic [fir_pkg::CFG_IDX_WIDTH-1:0] idx,
                            logic [fir_pkg::CFG_DATA_WIDTH-1:0] data);
        case (idx)
            fir_pkg::REG_TAP_COUNT:     tap_cnt = data;
            fir_pkg::REG_COMPLEX_INPUT: cplx_in = data[0];
            fir_pkg::REG_KEEP_IMAG:     keep_im = data[0];
            default: ;
        endcase
    endfunction

    // round half up by the tap fraction, then clip to the sample range
    function longint round_clip(longint acc, output bit clip);
        longint q;
        longint hi;
        longint lo;
        hi   = (longint'(1) <<< (TB_SW-1)) - 1;
        lo   = -hi - 1;
        q    = (acc + (longint'(1) <<< (fir_pkg::TAP_FRAC-1))) >>> fir_pkg::TAP_FRAC;
        clip = 0;
        if (q > hi) begin
            clip = 1;
            q    = hi;
        end else if (q < lo) begin
            clip = 1;
            q    = lo;
        end
        return q;
    endfunction

    // accepted input transfer: tap load or one filtered sample
    function void note_transfer(logic func, logic [TB_IN_W-1:0] data);
        longint      xre, xim, acc_re, acc_im, yre, yim;
        bit          clip_re, clip_im;
        int unsigned taps;
        int          k;
        t_filt_out   res;
        if (func == fir_pkg::FUNC_TAP) begin
            coef[data[2*TB_SW+3 -: 4]] = longint'($signed(data[2*TB_SW+19 -: 16]));
            return;
        end
        xre     = longint'($signed(data[TB_SW-1:0]));
        xim     = cplx_in ? longint'($signed(data[2*TB_SW-1:TB_SW])) : 0;
        yre     = 0;
        yim     = 0;
        clip_re = 0;
        clip_im = 0;
        taps    = (tap_cnt > TB_TAPS) ? TB_TAPS : tap_cnt;
        if (taps > 0) begin
            acc_re = xre * coef[0];
            acc_im = xim * coef[0];
            for (k = 1; k < taps; k++) begin
                acc_re += line_re[k-1] * coef[k];
                acc_im += line_im[k-1] * coef[k];
            end
            yre = round_clip(acc_re, clip_re);
            yim = round_clip(acc_im, clip_im);
            if (!keep_im) begin
                yim     = 0;
                clip_im = 0;
            end
        end
        // delay line shifts on every sample, whatever the tap count
        for (k = TB_TAPS-2; k > 0; k--) begin
            line_re[k] = line_re[k-1];
            line_im[k] = line_im[k-1];
        end
        line_re[0] = xre;
        line_im[0] = xim;
        res.re  = yre[TB_SW-1:0];
        res.im  = yim[TB_SW-1:0];
        res.sat = clip_re | clip_im;
        filtered_q.push_back(res);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // compare one output transfer with the oldest prediction
    task check_result(logic [TB_OUT_W-1:0] data, logic sat);
        t_filt_out want;
        if (filtered_q.size() == 0) begin
            report($sformatf("result with nothing pending: re=%0d im=%0d sat=%0b",
                             $signed(data[TB_SW-1:0]), $signed(data[2*TB_SW-1:TB_SW]), sat));
            return;
        end
        want = filtered_q.pop_front();
        if (data[TB_SW-1:0] !== want.re)
            report($sformatf("out_re %0d, predicted %0d",
                             $signed(data[TB_SW-1:0]), $signed(want.re)));
        if (data[2*TB_SW-1:TB_SW] !== want.im)
            report($sformatf("out_im %0d, predicted %0d",
                             $signed(data[2*TB_SW-1:TB_SW]), $signed(want.im)));
        if (sat !== want.sat)
            report($sformatf("saturated %0b, predicted %0b", sat, want.sat));
    endtask
endclass

module tb_fir_filter_direct_form;

    localparam int CYCLE_LIMIT = 1_000_000;
    // idle cycles after the last result before touching the registers
    localparam int SETTLE      = 4*(TB_TAPS+2);
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    // unmapped register index, writes to it must be dropped
    localparam logic [fir_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;
    localparam logic [TB_SW-1:0] W_MIN = 16'h8000;
    localparam logic [TB_SW-1:0] W_MAX = 16'h7fff;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [fir_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx = '0;
    logic [fir_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data = '0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    logic [TB_IN_W-1:0]                 i_s_axis_tdata = '0;
    logic                               i_s_axis_tuser = 1'b0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    logic [TB_OUT_W-1:0]                o_m_axis_tdata;
    logic                               o_m_axis_tuser;

    fir_scoreboard sb = new();
    int unsigned   cycles = 0;

    always #5 i_clk = ~i_clk;

    fir_filter_direct_form #(
        .MAX_TAPS     (TB_TAPS),
        .SAMPLE_WIDTH (TB_SW)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // sample_re, sample_im, tap_index, tap_value, fill
        .i_s_axis_tuser  (i_s_axis_tuser),  // func
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // out_re, out_im, fill
        .o_m_axis_tuser  (o_m_axis_tuser)   // saturated
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("fir_filter_direct_form verification failed");
            $finish;
        end
    end

    // output transfer check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // field value biased towards the extremes and small magnitudes
    function automatic logic [TB_SW-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return '1;
            3, 4:    return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver back-pressure, with occasional long stretches of no stall
    initial begin
        int run;
        int stall;
        @(negedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
            i_m_axis_tready <= 1'b1;
            repeat (run) @(negedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // one input transfer; entered and left just after a falling edge
    task automatic push_item(logic func, logic [TB_SW-1:0] re, logic [TB_SW-1:0] im,
                             logic [3:0] idx, logic [15:0] val, bit steady);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(TB_IN_W-2*TB_SW-20){1'b0}}, val, idx, im, re};
        i_s_axis_tuser  <= func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_transfer(i_s_axis_tuser, i_s_axis_tdata);
        @(negedge i_clk);
    endtask

    task automatic send_sample(logic [TB_SW-1:0] re, logic [TB_SW-1:0] im, bit steady);
        push_item(fir_pkg::FUNC_SAMPLE, re, im, 4'($urandom), 16'($urandom), steady);
    endtask

    task automatic send_tap(logic [3:0] idx, logic [15:0] val, bit steady);
        push_item(fir_pkg::FUNC_TAP, 16'($urandom), 16'($urandom), idx, val, steady);
    endtask

    // stop sending, wait for every pending result, then let the datapath empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [fir_pkg::CFG_IDX_WIDTH-1:0] idx,
                             logic [fir_pkg::CFG_DATA_WIDTH-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // register setting for one random phase; the first few are the extremes
    task automatic random_setup(int phase);
        logic [fir_pkg::CFG_DATA_WIDTH-1:0] n;
        case (phase)
            0:       n = 5'd16;
            1:       n = 5'd0;
            2:       n = 5'd31;
            3:       n = 5'd1;
            default: n = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                                     : 5'($urandom_range(2, 16));
        endcase
        write_reg(fir_pkg::REG_TAP_COUNT, n);
        write_reg(fir_pkg::REG_COMPLEX_INPUT, 5'($urandom));
        write_reg(fir_pkg::REG_KEEP_IMAG, 5'($urandom));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, 5'($urandom));
    endtask

    // stimulus
    initial begin
        int k;
        int j;
        bit steady;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero tap count after reset: zero results, delay line still fills
        send_sample(W_MAX, W_MIN, 1'b0);
        send_sample(W_MIN, W_MAX, 1'b0);
        send_tap(4'd0, W_MIN, 1'b0);
        send_sample(W_MIN, W_MIN, 1'b0);

        // single tap, complex in and out: most negative squared clips both parts
        settle();
        write_reg(fir_pkg::REG_TAP_COUNT, 5'd1);
        write_reg(fir_pkg::REG_COMPLEX_INPUT, 5'd1);
        write_reg(fir_pkg::REG_KEEP_IMAG, 5'd1);
        send_sample(W_MIN, W_MIN, 1'b1);
        send_sample(W_MAX, W_MIN, 1'b1);
        send_sample('0, '0, 1'b1);
        send_tap(4'd15, W_MAX, 1'b0);
        send_tap(4'd7, 16'hffff, 1'b0);
        send_tap(4'd1, 16'h4000, 1'b0);
        send_tap(4'd0, W_MAX, 1'b0);

        // tap count above the table size, real input (upper data bits set), unmapped index
        settle();
        write_reg(fir_pkg::REG_TAP_COUNT, 5'd31);
        write_reg(fir_pkg::REG_COMPLEX_INPUT, 5'b11110);
        write_reg(fir_pkg::REG_KEEP_IMAG, 5'b00000);
        write_reg(REG_SPARE, 5'b11111);
        send_sample(W_MAX, 16'h3039, 1'b0);
        send_sample(W_MIN, 16'hffff, 1'b0);
        send_sample(16'h4000, W_MAX, 1'b0);

        // complex input but imaginary part dropped: its clipping must not flag
        settle();
        write_reg(fir_pkg::REG_TAP_COUNT, 5'd16);
        write_reg(fir_pkg::REG_COMPLEX_INPUT, 5'd1);
        write_reg(fir_pkg::REG_KEEP_IMAG, 5'b10100);
        send_sample(W_MIN, W_MIN, 1'b1);
        send_sample(W_MAX, W_MAX, 1'b1);

        // random phases, each under its own setting
        for (k = 0; k < PHASES; k++) begin
            settle();
            random_setup(k);
            steady = ($urandom_range(0, 3) == 0);
            for (j = 0; j < PHASE_ITEMS; j++) begin
                if ((k == 0 && j == PHASE_ITEMS/2) || $urandom_range(0, 199) == 0)
                    settle();
                if ($urandom_range(0, 99) < 15)
                    send_tap(4'($urandom), pick_word(), steady);
                else
                    send_sample(pick_word(), pick_word(), steady);
            end
        end

        settle();
        if (sb.errors == 0)
            $display("fir_filter_direct_form verification clean");
        else
            $display("fir_filter_direct_form verification failed");
        $finish;
    end

endmodule
